// ----- src/mp4_box_stream_walker_top_defines.svh -----
// Assertion macros for the box stream walker.
// Used by mp4_box_stream_walker_top; needs clk and rst_n in scope.
`ifndef MP4_BOX_STREAM_WALKER_TOP_DEFINES_SVH
`define MP4_BOX_STREAM_WALKER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MBSW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define MBSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mbsw_pkg.sv -----
// Shared types and constants of the box stream walker.
// No dependencies.
package mbsw_pkg;

  // Container depth limit; the depth field is 4 bits wide
  localparam int unsigned MAX_DEPTH = 15;

  // Parse modes
  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_MDAT   = 2'd1;
  localparam logic [1:0] MODE_SKIP   = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_PAY = 2'd1;
  localparam logic [1:0] KIND_BAD = 2'd2;

  // Box types, first character in the top byte
  localparam logic [31:0] TYPE_MOOF = 32'h6D6F_6F66;
  localparam logic [31:0] TYPE_TRAF = 32'h7472_6166;
  localparam logic [31:0] TYPE_MDAT = 32'h6D64_6174;

  // One result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] box_type;
    logic [31:0] box_size;
    logic [3:0]  nest_depth;
    logic [7:0]  payload_byte;
    logic        last_of_payload;
  } result_t;

  // Pipeline control shared by the stages
  typedef struct packed {
    logic advance;  // every stage moves this cycle
    logic busy;     // input stage holds a word
  } pipe_ctl_t;

endpackage

// ----- src/mbsw_in_stage.sv -----
// Input register of the box stream walker.
// Depends on mbsw_pkg.
module mbsw_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_data_byte,
  input  logic               advance,
  output mbsw_pkg::pipe_ctl_t ctl,
  output logic [7:0]         byte_q
);
  import mbsw_pkg::*;

  logic       valid_r;
  logic [7:0] byte_r;

  // control: one word slot, moves whenever the pipe advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      byte_r <= in_data_byte;
    end
  end

  assign ctl.advance = advance;
  assign ctl.busy    = valid_r;
  assign byte_q      = byte_r;

endmodule

// ----- src/mbsw_walk.sv -----
// Box header parser and payload counter of the box stream walker.
// Depends on mbsw_pkg.
module mbsw_walk #(
  parameter int unsigned MAX_DEPTH = mbsw_pkg::MAX_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mbsw_pkg::pipe_ctl_t ctl,
  input  logic [7:0]          byte_q,
  output logic                res_valid,
  output mbsw_pkg::result_t   res
);
  import mbsw_pkg::*;

  localparam logic [3:0] DEPTH_CAP = (MAX_DEPTH < 15) ? 4'(MAX_DEPTH) : 4'd15;

  logic [55:0] shift_r, shift_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [3:0]  depth_r, depth_nxt;

  logic [63:0] hdr_word;
  logic [31:0] size_w;
  logic [31:0] type_w;
  logic        rem_last;
  logic        en;

  assign en       = ctl.advance && ctl.busy;
  assign hdr_word = {shift_r, byte_q};
  assign size_w   = hdr_word[63:32];
  assign type_w   = hdr_word[31:0];
  assign rem_last = (rem_r[31:1] == 31'd0);

  // next state and result for the word in the input register
  always_comb begin
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    res_valid = 1'b0;
    res       = '0;
    res.nest_depth = depth_r;
    unique case (mode_r)
      MODE_MDAT: begin
        res_valid           = 1'b1;
        res.kind            = KIND_PAY;
        res.payload_byte    = byte_q;
        res.last_of_payload = rem_last;
        rem_nxt  = rem_last ? 32'd0 : rem_r - 32'd1;
        mode_nxt = rem_last ? MODE_HEADER : MODE_MDAT;
      end
      MODE_SKIP: begin
        rem_nxt  = rem_last ? 32'd0 : rem_r - 32'd1;
        mode_nxt = rem_last ? MODE_HEADER : MODE_SKIP;
      end
      default: begin
        // header mode; the unused code falls back here
        mode_nxt = MODE_HEADER;
        if (cnt_r == 3'd7) begin
          cnt_nxt      = 3'd0;
          res_valid    = 1'b1;
          res.box_type = type_w;
          res.box_size = size_w;
          if (size_w < 32'd8) begin
            res.kind = KIND_BAD;
          end else begin
            res.kind = KIND_HDR;
            if (type_w == TYPE_MOOF || type_w == TYPE_TRAF) begin
              if (depth_r < DEPTH_CAP) depth_nxt = depth_r + 4'd1;
            end else begin
              rem_nxt = size_w - 32'd8;
              if (size_w != 32'd8) begin
                mode_nxt = (type_w == TYPE_MDAT) ? MODE_MDAT : MODE_SKIP;
              end
            end
          end
        end else begin
          cnt_nxt   = cnt_r + 3'd1;
          shift_nxt = hdr_word[55:0];
        end
      end
    endcase
    // no result without a word in the input register
    if (!ctl.busy) res_valid = 1'b0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 3'd0;
      rem_r   <= 32'd0;
      mode_r  <= MODE_HEADER;
      depth_r <= 4'd0;
      shift_r <= 56'd0;
    end else if (en) begin
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

// ----- src/mbsw_out_stage.sv -----
// Result register of the box stream walker; generates the pipe advance.
// Depends on mbsw_pkg.
module mbsw_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              out_stall,
  input  logic              res_valid,
  input  mbsw_pkg::result_t res,
  output logic              advance,
  output logic              out_valid,
  output mbsw_pkg::result_t res_q
);
  import mbsw_pkg::*;

  logic    valid_r;
  result_t res_r;

  // pipe moves when the result slot is empty or being taken
  assign advance = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign res_q     = res_r;

endmodule

// ----- src/mp4_box_stream_walker_top.sv -----
// Top level of the media file box stream walker.
// Depends on mbsw_pkg, mbsw_in_stage, mbsw_walk, mbsw_out_stage and the defines header.
//
// Usage:
//   Input channel: one file byte per word on in_data_byte, taken when
//   in_valid is high and in_stall is low.
//   Result channel: out_kind tells a box header report, an mdat payload
//   byte or a malformed header (size below 8). A word is taken when
//   out_valid is high and out_stall is low.
//   Path: the byte that causes a result is held in the input register, then
//   the result is written to the result register, where it waits until it
//   is taken.
//   Throughput: one byte per cycle while out_stall does not hold the pipe;
//   the parser updates its counters and header shift register for each byte.
//   Bytes that cause no result (header bytes before the eighth, skipped
//   payload) leave nothing on the result channel.
//   Stall: while the result register holds an untaken word and out_stall
//   is high, the whole pipe holds and in_stall is raised.
//   Reset: rst_n low for one clock empties both registers, returns the
//   parser to header mode at depth zero.
`include "mp4_box_stream_walker_top_defines.svh"

module mp4_box_stream_walker_top #(
  parameter int unsigned MAX_DEPTH = mbsw_pkg::MAX_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_box_type,
  output logic [31:0] out_box_size,
  output logic [3:0]  out_nest_depth,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_of_payload
);
  import mbsw_pkg::*;

  logic      advance;
  pipe_ctl_t ctl;
  logic [7:0] byte_q;
  logic      res_valid;
  result_t   res;
  result_t   res_q;

  mbsw_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .advance      (advance),
    .ctl          (ctl),
    .byte_q       (byte_q)
  );

  mbsw_walk #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .byte_q    (byte_q),
    .res_valid (res_valid),
    .res       (res)
  );

  mbsw_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_stall (out_stall),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign in_stall            = !advance;
  assign out_kind            = res_q.kind;
  assign out_box_type        = res_q.box_type;
  assign out_box_size        = res_q.box_size;
  assign out_nest_depth      = res_q.nest_depth;
  assign out_payload_byte    = res_q.payload_byte;
  assign out_last_of_payload = res_q.last_of_payload;

  // checks
  `MBSW_ASSERT_NOW(a_kind_legal, out_valid, (out_kind == KIND_HDR || out_kind == KIND_PAY || out_kind == KIND_BAD), "unknown result kind")
  `MBSW_ASSERT_NOW(a_pay_clean, out_valid && out_kind == KIND_PAY, (out_box_type == 32'd0 && out_box_size == 32'd0), "payload word carries header fields")
  `MBSW_ASSERT_NOW(a_bad_small, out_valid && out_kind == KIND_BAD, (out_box_size < 32'd8 && !out_last_of_payload), "malformed report with legal size")
  `MBSW_ASSERT_NEXT(a_hdr_flags, out_valid && !out_stall && (out_kind == KIND_HDR), (!out_valid || out_kind != KIND_HDR || out_payload_byte == 8'd0), "header report with payload byte")

endmodule
